>>> design/tssm_pkg.sv
// Shared types and codes for the two-stack shared-memory core.
`default_nettype none

package tssm_pkg;

    localparam int CAP_W = 11;
    localparam int VAL_W = 32;

    localparam logic [1:0] REQ_PUSH_LOW  = 2'd0;
    localparam logic [1:0] REQ_PUSH_HIGH = 2'd1;
    localparam logic [1:0] REQ_POP_LOW   = 2'd2;
    localparam logic [1:0] REQ_POP_HIGH  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [VAL_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] pop_value;
        logic [1:0]              status;
    } out_item_t;

endpackage

`default_nettype wire

>>> design/tssm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while no read is issued
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/two_stacks_shared_memory_core.sv
// Top level: two LIFO stacks growing toward each other in one shared RAM.
//
//  channel | dir | payload            | handshake
//  --------+-----+--------------------+-------------------------
//  in      | in  | in_data  (34 bits) | in_valid  / in_ready
//  out     | out | out_data (34 bits) | out_valid / out_ready
//  cfg     | in  | cfg_data (11 bits) | cfg_valid / cfg_ready
//
//  Read path: an accepted item passes the request stage (RAM read register)
//  and then the output register before out_valid rises.
//  Throughput: one item per cycle while out_ready stays high; the single RAM
//  port pair and the one-deep request stage set this figure.
//  Reset: both stacks empty, capacity = min(1024, DEPTH). The RAM is not
//  cleared; only entries pushed since the last reset or capacity write are read.
//  Stalls: while a result waits with out_ready low, one more item can enter the
//  request stage; then in_ready drops and the RAM read data is frozen until the
//  stage drains.
`default_nettype none

module two_stacks_shared_memory_core #(
    parameter int DEPTH = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire tssm_pkg::in_item_t        in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output tssm_pkg::out_item_t            out_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [tssm_pkg::CAP_W-1:0] cfg_data
);

    import tssm_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    // reset capacity 1024, saturated at DEPTH
    localparam int CAP_RST = (DEPTH < 1024) ? DEPTH : 1024;

    // ---------------- state registers ----------------
    logic [CNT_W-1:0] cap_reg,  cap_next;
    logic [CNT_W-1:0] low_reg,  low_next;
    logic [CNT_W-1:0] high_reg, high_next;

    // request stage: holds the request while the RAM read data is registered
    logic             pend_valid_reg,  pend_valid_next;
    logic             pend_pop_reg,    pend_pop_next;
    logic [1:0]       pend_status_reg, pend_status_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg,  out_data_next;

    // ---------------- handshakes ----------------
    logic in_fire;
    logic cfg_fire;
    logic pend_adv;

    assign pend_adv  = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pend_valid_reg || pend_adv;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    // ---------------- request decode ----------------
    logic [CNT_W:0]   used;
    logic             full;
    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;
    logic [CNT_W-1:0] wr_idx;
    logic [CNT_W-1:0] rd_idx;
    logic [LW-1:0]    cap_wide;

    assign used = {1'b0, low_reg} + {1'b0, high_reg};
    assign full = (used >= {1'b0, cap_reg});

    always_comb
    begin
        low_next         = low_reg;
        high_next        = high_reg;
        cap_next         = cap_reg;
        pend_valid_next  = pend_valid_reg;
        pend_pop_next    = pend_pop_reg;
        pend_status_next = pend_status_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        wr_idx           = low_reg;
        rd_idx           = low_reg - CNT_W'(1);

        if (pend_adv)
        begin
            pend_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            pend_valid_next  = 1'b1;
            pend_pop_next    = 1'b0;
            pend_status_next = ST_OK;
            case (in_data.req_type)
                REQ_PUSH_LOW:
                begin
                    if (full)
                    begin
                        pend_status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        wr_idx   = low_reg;
                        low_next = low_reg + CNT_W'(1);
                    end
                end
                REQ_PUSH_HIGH:
                begin
                    if (full)
                    begin
                        pend_status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        wr_idx    = cap_reg - CNT_W'(1) - high_reg;
                        high_next = high_reg + CNT_W'(1);
                    end
                end
                REQ_POP_LOW:
                begin
                    if (low_reg == '0)
                    begin
                        pend_status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ram_re        = 1'b1;
                        pend_pop_next = 1'b1;
                        rd_idx        = low_reg - CNT_W'(1);
                        low_next      = low_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    if (high_reg == '0)
                    begin
                        pend_status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ram_re        = 1'b1;
                        pend_pop_next = 1'b1;
                        rd_idx        = cap_reg - high_reg;
                        high_next     = high_reg - CNT_W'(1);
                    end
                end
            endcase
        end

        // capacity write empties both stacks
        cap_wide = LW'(cfg_data);
        if (cfg_fire)
        begin
            cap_next  = (cap_wide > LW'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_wide);
            low_next  = '0;
            high_next = '0;
        end
    end

    assign ram_waddr = wr_idx[AW-1:0];
    assign ram_raddr = rd_idx[AW-1:0];

    tssm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_data.push_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pend_adv)
        begin
            out_valid_next          = 1'b1;
            out_data_next.pop_value = pend_pop_reg ? ram_rdata : '0;
            out_data_next.status    = pend_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CNT_W'(CAP_RST);
            low_reg        <= '0;
            high_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cap_reg        <= cap_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pop_reg    <= pend_pop_next;
        pend_status_reg <= pend_status_next;
        out_data_reg    <= out_data_next;
    end

    // ---------------- assertions ----------------
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        used <= {1'b0, cap_reg})
        else $error("stacks overlap: occupancy above capacity");

    a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg <= CNT_W'(DEPTH))
        else $error("effective capacity above DEPTH");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pend_adv |=> out_valid_reg)
        else $error("request stage advanced but no result registered");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !cfg_fire && !full
        && (in_data.req_type == REQ_PUSH_LOW || in_data.req_type == REQ_PUSH_HIGH)
        |=> used == $past(used) + (CNT_W+1)'(1))
        else $error("accepted push did not grow occupancy by one");

    a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> in_fire && !full || ram_re && in_fire)
        else $error("RAM read issued without an accepted pop");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the two-stack shared-memory core.
`timescale 1ns / 1ps

module testbench;

    import tssm_pkg::*;

    localparam int MEM_DEPTH = 1024;

    // Tracks both stacks and the queue of results still owed by the core.
    class stack_scoreboard;
        logic [VAL_W-1:0] mem [MEM_DEPTH];
        int unsigned      low_cnt  = 0;
        int unsigned      high_cnt = 0;
        int unsigned      cap      = 1024;
        out_item_t        owed_q [$];
        int               errors    = 0;
        int               requests  = 0;
        int               results   = 0;
        int               overflows = 0;
        int               underflows = 0;
        int               cap_writes = 0;

        task report(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_capacity(logic [CAP_W-1:0] value);
            cap      = 32'(value);
            low_cnt  = 0;
            high_cnt = 0;
            cap_writes++;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Predict the result of one accepted request and queue it.
        function void note_request(in_item_t item);
            out_item_t   exp_item;
            int unsigned eff_cap;
            bit          full;
            eff_cap = (cap > MEM_DEPTH) ? MEM_DEPTH : cap;
            full = (low_cnt + high_cnt) >= eff_cap;
            exp_item.pop_value = '0;
            exp_item.status    = ST_OK;
            case (item.req_type)
                REQ_PUSH_LOW:
                    if (full)
                        exp_item.status = ST_OVERFLOW;
                    else
                    begin
                        mem[low_cnt] = item.push_value;
                        low_cnt++;
                    end
                REQ_PUSH_HIGH:
                    if (full)
                        exp_item.status = ST_OVERFLOW;
                    else
                    begin
                        mem[eff_cap - 1 - high_cnt] = item.push_value;
                        high_cnt++;
                    end
                REQ_POP_LOW:
                    if (low_cnt == 0)
                        exp_item.status = ST_UNDERFLOW;
                    else
                    begin
                        low_cnt--;
                        exp_item.pop_value = mem[low_cnt];
                    end
                default:
                    if (high_cnt == 0)
                        exp_item.status = ST_UNDERFLOW;
                    else
                    begin
                        high_cnt--;
                        exp_item.pop_value = mem[eff_cap - 1 - high_cnt];
                    end
            endcase
            if (exp_item.status == ST_OVERFLOW)
                overflows++;
            if (exp_item.status == ST_UNDERFLOW)
                underflows++;
            requests++;
            owed_q.push_back(exp_item);
        endfunction

        task check_result(out_item_t got);
            out_item_t exp_item;
            results++;
            if (owed_q.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing owed", results));
                return;
            end
            exp_item = owed_q.pop_front();
            if (got.pop_value !== exp_item.pop_value)
                report($sformatf("result %0d pop_value %h, want %h",
                                 results, got.pop_value, exp_item.pop_value));
            if (got.status !== exp_item.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 results, got.status, exp_item.status));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data;

    stack_scoreboard sb = new;

    // Set for the closing phase: no gaps on either side.
    bit calm = 1'b0;

    two_stacks_shared_memory_core #(
        .DEPTH(MEM_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Results are sampled at the rising edge, before the core's flops update.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Receiver: random stall bursts with out_ready low, long open stretches too.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic in_item_t make_req(logic [1:0] op, logic [VAL_W-1:0] value);
        in_item_t item;
        item.req_type   = op;
        item.push_value = value;
        return item;
    endfunction

    // push_pct sets how hard the stacks are driven toward each other.
    function automatic in_item_t rand_request(int push_pct);
        logic [1:0]       op;
        logic [VAL_W-1:0] value;
        bit               high_side;
        high_side = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < push_pct)
            op = high_side ? REQ_PUSH_HIGH : REQ_PUSH_LOW;
        else
            op = high_side ? REQ_POP_HIGH : REQ_POP_LOW;
        case ($urandom_range(0, 15))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'hFFFF_FFFF;
            3:       value = 32'h0000_0000;
            default: value = $urandom;
        endcase
        return make_req(op, value);
    endfunction

    // Present one item and hold it until the core takes it.
    task automatic send_request(in_item_t item);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(item);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge clk);
        end
    endtask

    // Capacity is only changed with the core drained; idle cycles follow the last result.
    task automatic apply_capacity(logic [CAP_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_capacity(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [CAP_W-1:0] value, int count, int push_pct);
        apply_capacity(value);
        repeat (count) send_request(rand_request(push_pct));
    endtask

    int unsigned phase_cap [11] = '{1, 2, 3, 0, 7, 16, 2047, 5, 64, 1024, 1500};
    int          phase_len [11] = '{165, 165, 165, 40, 165, 165, 165, 165, 165, 165, 165};

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b1;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset capacity: empty pops, value extremes, pop order on both sides,
        // and a pop carrying a nonzero (ignored) push_value.
        send_request(make_req(REQ_POP_LOW,   32'h0));
        send_request(make_req(REQ_POP_HIGH,  32'h0));
        send_request(make_req(REQ_PUSH_LOW,  32'h7FFF_FFFF));
        send_request(make_req(REQ_PUSH_HIGH, 32'h8000_0000));
        send_request(make_req(REQ_PUSH_LOW,  32'h0));
        send_request(make_req(REQ_PUSH_HIGH, 32'hFFFF_FFFF));
        send_request(make_req(REQ_POP_HIGH,  32'hDEAD_BEEF));
        send_request(make_req(REQ_POP_LOW,   32'h0));
        send_request(make_req(REQ_POP_LOW,   32'h0));
        send_request(make_req(REQ_POP_HIGH,  32'h0));

        // One entry: whichever stack takes it, the other overflows.
        apply_capacity(11'd1);
        send_request(make_req(REQ_PUSH_LOW,  32'h1234_5678));
        send_request(make_req(REQ_PUSH_HIGH, 32'h1));
        send_request(make_req(REQ_POP_HIGH,  32'h0));
        send_request(make_req(REQ_POP_LOW,   32'h0));
        send_request(make_req(REQ_PUSH_HIGH, 32'hA5A5_A5A5));
        send_request(make_req(REQ_PUSH_LOW,  32'h2));
        send_request(make_req(REQ_POP_HIGH,  32'h0));

        // No entries at all: everything is refused.
        apply_capacity(11'd0);
        send_request(make_req(REQ_PUSH_LOW,  32'h5));
        send_request(make_req(REQ_PUSH_HIGH, 32'h6));
        send_request(make_req(REQ_POP_LOW,   32'h0));
        send_request(make_req(REQ_POP_HIGH,  32'h0));

        // Oversized capacity saturates; high stack starts at the top entry.
        apply_capacity(11'h7FF);
        send_request(make_req(REQ_PUSH_HIGH, 32'hC0DE_0001));
        send_request(make_req(REQ_POP_HIGH,  32'h0));
        send_request(make_req(REQ_POP_HIGH,  32'h0));

        for (int p = 0; p < 11; p++)
            run_phase(CAP_W'(phase_cap[p]), phase_len[p],
                      (phase_cap[p] >= 64) ? $urandom_range(70, 85)
                                           : $urandom_range(35, 65));

        // Closing phase at full rate on both sides.
        calm = 1'b1;
        run_phase(CAP_W'($urandom_range(2, 12)), 150, 50);

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("covered %0d requests under %0d capacity settings",
                 sb.requests, sb.cap_writes + 1);
        $display("%0d results checked, %0d overflows, %0d underflows, %0d mismatches",
                 sb.results, sb.overflows, sb.underflows, sb.errors);
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("timeout with %0d results still owed", sb.pending());
        $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> sim.f
design/tssm_pkg.sv
design/tssm_ram.sv
design/two_stacks_shared_memory_core.sv
tb/sv/testbench.sv
